// ===== src/mono_page_framebuffer_draw_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome page frame buffer draw unit
// Shared helpers that wrap concurrent properties with a common report form.
// ----------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_UNIT_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside of rst.
`define MPFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside of rst.
`define MPFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfd_pkg
// Types and constants shared by the page frame buffer draw unit and its store.
// ----------------------------------------------------------------------------
package mpfd_pkg;

   localparam int DEF_COLUMNS = 84;
   localparam int DEF_PAGES   = 6;
   localparam int ROWS_PER_PAGE = 8;
   localparam logic [7:0] BYTE_ONES = 8'hff;

   localparam logic [2:0] OP_PIXEL = 3'd0;
   localparam logic [2:0] OP_HLINE = 3'd1;
   localparam logic [2:0] OP_VLINE = 3'd2;
   localparam logic [2:0] OP_RECT  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [6:0] x_start;
      logic [6:0] x_end;
      logic [5:0] y_start;
      logic [5:0] y_end;
      logic       color;
   } mpfd_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
   } mpfd_rsp_type;

   // Read-modify-write command to the frame store.
   typedef struct packed {
      logic       valid;
      logic       color;
      logic [7:0] mask;
   } mpfd_wr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_DRAIN,
      ST_READ,
      ST_FETCH,
      ST_DONE
   } mpfd_state_type;

endpackage

// ===== src/mpfd_store.sv =====
// ----------------------------------------------------------------------------
// mpfd_store
// Frame store memory with one registered read port, a masked merge write port
// and a clearing sweep that runs once after reset.
// ----------------------------------------------------------------------------
module mpfd_store #(
   parameter int DEPTH = mpfd_pkg::DEF_COLUMNS * mpfd_pkg::DEF_PAGES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [7:0]            rd_data,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  mpfd_pkg::mpfd_wr_type wr,
   output logic                  clear_busy
);
   import mpfd_pkg::*;

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              busy_ff, busy_in;
   logic [7:0]        merged;

   // The write lands in the cycle after its read, so rd_data_ff holds the old byte.
   assign merged = wr.color ? (rd_data_ff | wr.mask) : (rd_data_ff & ~wr.mask);

   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (busy_ff) begin
         if (clr_ff == ADDR_W'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr.valid) begin
         mem[wr_addr] <= merged;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = busy_ff;

endmodule

// ===== src/mono_page_framebuffer_draw_unit.sv =====
// Each draw item walks B store bytes, where B is the number of bytes touched
// (columns in range times pages in range), so up to COLUMNS*PAGES; one byte
// read-modify-write per cycle through the store port. Read items fetch one byte;
// empty or unused items go straight to the result. One item at a time.
// After reset the store is swept to zero, one byte a cycle over all COLUMNS*PAGES
// bytes (504 by default), and no item is accepted until the sweep ends.
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_unit
// Page-organized 1 bpp frame buffer with pixel, line, rectangle and read items.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw_unit #(
   parameter int COLUMNS = mpfd_pkg::DEF_COLUMNS,
   parameter int PAGES   = mpfd_pkg::DEF_PAGES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mpfd_pkg::mpfd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mpfd_pkg::mpfd_rsp_type rsp_data
);
   import mpfd_pkg::*;

   localparam int DEPTH  = COLUMNS * PAGES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROWS   = PAGES * ROWS_PER_PAGE;
   localparam logic [7:0] COL_LIM  = 8'(COLUMNS);
   localparam logic [6:0] COL_MAX  = 7'(COLUMNS - 1);
   localparam logic [6:0] ROW_LIM  = 7'(ROWS);
   localparam logic [5:0] ROW_MAX  = 6'(ROWS - 1);
   localparam logic [6:0] PAGE_LIM = 7'(PAGES);

   mpfd_state_type state_ff, state_in;

   // Decode of the item at the input
   logic       is_draw, is_read, draw_go, read_hit;
   logic [6:0] x_lo, x_hi, x_hi_c;
   logic [5:0] y_lo, y_hi, y_hi_c;
   logic [2:0] p_lo;

   // Latched item
   logic       is_read_ff, color_ff;
   logic [6:0] clo_ff, chi_ff, col_ff;
   logic [2:0] plo_ff, phi_ff, page_ff, blo_ff, bhi_ff;

   // Walk address and pipeline stage toward the write port
   logic [ADDR_W-1:0] row_base_ff, addr_ff, s1_addr_ff;
   logic              s1_valid_ff;
   logic [7:0]        s1_mask_ff;
   logic [2:0]        bit_lo, bit_hi;
   logic [7:0]        mask;
   logic              last;

   // Result
   logic [7:0]   res_data_ff;
   logic         res_hit_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   mpfd_rsp_type rsp_data_ff;

   // Controls
   logic        accept, do_setup, do_walk, do_fetch, out_free, out_load;
   logic [7:0]  rd_data;
   logic        clear_busy;
   mpfd_wr_type wr;

   always_comb begin
      is_draw = 1'b0;
      is_read = 1'b0;
      x_lo    = req_data.x_start;
      x_hi    = req_data.x_start;
      y_lo    = req_data.y_start;
      y_hi    = req_data.y_start;
      unique case (req_data.opcode)
         OP_PIXEL: begin
            is_draw = 1'b1;
         end
         OP_HLINE: begin
            is_draw = 1'b1;
            if (req_data.x_start > req_data.x_end) begin
               x_lo = req_data.x_end;
            end else begin
               x_hi = req_data.x_end;
            end
         end
         OP_VLINE, OP_RECT: begin
            is_draw = (req_data.opcode == OP_VLINE) ||
                      (req_data.x_start <= req_data.x_end);
            if (req_data.opcode == OP_RECT) begin
               x_hi = req_data.x_end;
            end
            if (req_data.y_start > req_data.y_end) begin
               y_lo = req_data.y_end;
            end else begin
               y_hi = req_data.y_end;
            end
         end
         OP_READ: begin
            is_read = 1'b1;
         end
         default: begin
         end
      endcase
      x_hi_c   = ({1'b0, x_hi} >= COL_LIM) ? COL_MAX : x_hi;
      y_hi_c   = ({1'b0, y_hi} >= ROW_LIM) ? ROW_MAX : y_hi;
      p_lo     = is_read ? req_data.y_start[2:0] : y_lo[5:3];
      draw_go  = is_draw && ({1'b0, x_lo} < COL_LIM) && ({1'b0, y_lo} < ROW_LIM);
      read_hit = is_read && ({1'b0, req_data.x_start} < COL_LIM) &&
                 ({1'b0, req_data.y_start} < PAGE_LIM);
   end

   assign last = (col_ff == chi_ff) && (page_ff == phi_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (!clear_busy) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (draw_go || read_hit) ? ST_SETUP : ST_DONE;
            end
         end
         ST_SETUP: state_in = is_read_ff ? ST_READ : ST_WALK;
         ST_WALK:  if (last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_READ:  state_in = ST_FETCH;
         ST_FETCH: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      do_setup  = 1'b0;
      do_walk   = 1'b0;
      do_fetch  = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SETUP: do_setup  = 1'b1;
         ST_WALK:  do_walk   = 1'b1;
         ST_FETCH: do_fetch  = 1'b1;
         ST_DONE:  out_load  = out_free;
         default: begin
         end
      endcase
   end

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Bits of the current page that fall inside the row range.
   assign bit_lo = (page_ff == plo_ff) ? blo_ff : 3'd0;
   assign bit_hi = (page_ff == phi_ff) ? bhi_ff : 3'd7;
   assign mask   = (BYTE_ONES << bit_lo) & (BYTE_ONES >> (3'd7 - bit_hi));

   always_ff @(posedge clock) begin
      if (accept) begin
         is_read_ff  <= is_read;
         color_ff    <= req_data.color;
         clo_ff      <= x_lo;
         chi_ff      <= x_hi_c;
         plo_ff      <= p_lo;
         phi_ff      <= y_hi_c[5:3];
         blo_ff      <= y_lo[2:0];
         bhi_ff      <= y_hi_c[2:0];
         res_data_ff <= '0;
         res_hit_ff  <= read_hit;
      end
      if (do_setup) begin
         row_base_ff <= ADDR_W'(int'(plo_ff) * COLUMNS);
         addr_ff     <= ADDR_W'(int'(plo_ff) * COLUMNS) + ADDR_W'(clo_ff);
         col_ff      <= clo_ff;
         page_ff     <= plo_ff;
      end else if (do_walk && !last) begin
         if (col_ff == chi_ff) begin
            row_base_ff <= row_base_ff + ADDR_W'(COLUMNS);
            addr_ff     <= row_base_ff + ADDR_W'(COLUMNS) + ADDR_W'(clo_ff);
            col_ff      <= clo_ff;
            page_ff     <= page_ff + 1'b1;
         end else begin
            addr_ff <= addr_ff + 1'b1;
            col_ff  <= col_ff + 1'b1;
         end
      end
      s1_addr_ff <= addr_ff;
      s1_mask_ff <= mask;
      if (do_fetch) begin
         res_data_ff <= rd_data;
      end
      if (out_load) begin
         rsp_data_ff.read_data  <= res_data_ff;
         rsp_data_ff.read_valid <= res_hit_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= do_walk;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign wr.valid = s1_valid_ff;
   assign wr.color = color_ff;
   assign wr.mask  = s1_mask_ff;

   mpfd_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (addr_ff),
      .rd_data    (rd_data),
      .wr_addr    (s1_addr_ff),
      .wr         (wr),
      .clear_busy (clear_busy)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/mpfd_checker.sv =====
// ----------------------------------------------------------------------------
// mpfd_checker
// Port-level checks of the draw unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "mono_page_framebuffer_draw_unit_defines.svh"

module mpfd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input mpfd_pkg::mpfd_rsp_type rsp_data
);
   import mpfd_pkg::*;

   // The store sweep keeps the unit busy and the result channel empty after reset.
   `MPFD_ASSERT_IMP(a_busy_after_reset, clock, 1'b0, $past(reset),
                    !req_ready && !rsp_valid, "unit not busy after reset")

   // One item at a time: the cycle after an item is taken, no other is taken.
   `MPFD_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready,
                    !req_ready, "item taken while busy")

   // A result that is not a read hit carries a zero byte.
   `MPFD_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_data.read_valid,
                    rsp_data.read_data == 8'h00, "nonzero data without read hit")

   // A stalled result holds.
   `MPFD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind mono_page_framebuffer_draw_unit mpfd_checker u_mpfd_checker (.*);
